@@ rtl/lrcts_pkg.sv @@
// Shared definitions for the lyric timestamp parser: widths, characters,
// parse phases, the result snapshot type and the digit helpers.
// No dependencies.
package lrcts_pkg;

  localparam int MINUTE_BITS     = 14;
  localparam int SECOND_BITS     = 14;
  localparam int FRACTION_DIGITS = 3;
  localparam int FRAC_BITS       = 10;
  localparam int FCOUNT_BITS     = 2;
  localparam int TIME_BITS       = 30;

  localparam int MIN_PROD_BITS = MINUTE_BITS + 16;
  localparam int SEC_PROD_BITS = SECOND_BITS + 10;
  localparam int PROD_MAX_BITS = (MIN_PROD_BITS > SEC_PROD_BITS) ? MIN_PROD_BITS : SEC_PROD_BITS;
  localparam int SUM_BITS      = ((PROD_MAX_BITS > TIME_BITS) ? PROD_MAX_BITS : TIME_BITS) + 1;

  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
  localparam logic [9:0]  MS_PER_SECOND = 10'd1000;

  localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  localparam logic STATUS_TIME = 1'b0;
  localparam logic STATUS_END  = 1'b1;

  typedef enum logic [2:0] {
    PH_OPEN,
    PH_MIN_FIRST,
    PH_MIN,
    PH_SEC_FIRST,
    PH_SEC,
    PH_FRAC,
    PH_DEAD
  } phase_t;

  typedef struct packed {
    logic                   status;
    logic [MINUTE_BITS-1:0] minutes;
    logic [SECOND_BITS-1:0] seconds;
    logic [FRAC_BITS-1:0]   fraction;
    logic [FCOUNT_BITS-1:0] fraction_count;
  } snap_t;

  // acc * 10 + d, saturating at all ones.
  function automatic logic [MINUTE_BITS-1:0] add_minute_digit(
      input logic [MINUTE_BITS-1:0] acc, input logic [3:0] d);
    logic [MINUTE_BITS+3:0] v;
    v = (MINUTE_BITS+4)'(acc) * (MINUTE_BITS+4)'(10) + (MINUTE_BITS+4)'(d);
    if (|v[MINUTE_BITS+3:MINUTE_BITS]) return '1;
    return v[MINUTE_BITS-1:0];
  endfunction

  function automatic logic [SECOND_BITS-1:0] add_second_digit(
      input logic [SECOND_BITS-1:0] acc, input logic [3:0] d);
    logic [SECOND_BITS+3:0] v;
    v = (SECOND_BITS+4)'(acc) * (SECOND_BITS+4)'(10) + (SECOND_BITS+4)'(d);
    if (|v[SECOND_BITS+3:SECOND_BITS]) return '1;
    return v[SECOND_BITS-1:0];
  endfunction

endpackage

@@ rtl/lrcts_parse.sv @@
// Byte-level parse state machine of the lyric timestamp parser, with the
// register that holds a finished timestamp snapshot. Depends on lrcts_pkg.
module lrcts_parse import lrcts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] byte_value,
  input  logic       restart,
  input  logic       snap_ready,
  output logic       snap_valid,
  output snap_t      snap
);

  phase_t                 phase, phase_next, cur_phase;
  logic [MINUTE_BITS-1:0] minutes_acc, minutes_next, cur_minutes;
  logic [SECOND_BITS-1:0] seconds_acc, seconds_next, cur_seconds;
  logic [FRAC_BITS-1:0]   fraction_acc, fraction_next, cur_fraction;
  logic [FCOUNT_BITS-1:0] fraction_count, fcount_next, cur_fcount;
  logic                   is_digit;
  logic [3:0]             digit;
  logic                   emit;
  logic                   finish;
  logic [FRAC_BITS+3:0]   frac_wide;

  // A restart clears the parse state before this byte is looked at.
  assign cur_phase    = restart ? PH_OPEN : phase;
  assign cur_minutes  = restart ? '0 : minutes_acc;
  assign cur_seconds  = restart ? '0 : seconds_acc;
  assign cur_fraction = restart ? '0 : fraction_acc;
  assign cur_fcount   = restart ? '0 : fraction_count;

  assign is_digit  = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
  assign digit     = is_digit ? 4'(byte_value - CH_ZERO) : 4'd0;
  assign frac_wide = (FRAC_BITS+4)'(cur_fraction) * (FRAC_BITS+4)'(10) + (FRAC_BITS+4)'(digit);

  always_comb begin
    phase_next = PH_DEAD;
    unique case (cur_phase)
      PH_OPEN: begin
        phase_next = (byte_value == CH_OPEN) ? PH_MIN_FIRST : PH_DEAD;
      end
      PH_MIN_FIRST: begin
        phase_next = is_digit ? PH_MIN : PH_DEAD;
      end
      PH_MIN: begin
        if (is_digit) phase_next = PH_MIN;
        else if (byte_value == CH_COLON) phase_next = PH_SEC_FIRST;
        else phase_next = PH_DEAD;
      end
      PH_SEC_FIRST: begin
        phase_next = is_digit ? PH_SEC : PH_DEAD;
      end
      PH_SEC: begin
        if (is_digit) phase_next = PH_SEC;
        else if (byte_value == CH_DOT || byte_value == CH_COMMA) phase_next = PH_FRAC;
        else if (byte_value == CH_CLOSE) phase_next = PH_OPEN;
        else phase_next = PH_DEAD;
      end
      PH_FRAC: begin
        if (is_digit) phase_next = PH_FRAC;
        else if (byte_value == CH_CLOSE) phase_next = PH_OPEN;
        else phase_next = PH_DEAD;
      end
      default: begin
        phase_next = PH_DEAD;
      end
    endcase
  end

  always_comb begin
    emit          = 1'b0;
    finish        = 1'b0;
    minutes_next  = cur_minutes;
    seconds_next  = cur_seconds;
    fraction_next = cur_fraction;
    fcount_next   = cur_fcount;
    if (cur_phase != PH_DEAD && phase_next == PH_DEAD) begin
      emit = 1'b1;
    end else if (cur_phase != PH_OPEN && phase_next == PH_OPEN) begin
      emit   = 1'b1;
      finish = 1'b1;
    end else if (is_digit) begin
      unique case (cur_phase)
        PH_MIN_FIRST, PH_MIN: minutes_next = add_minute_digit(cur_minutes, digit);
        PH_SEC_FIRST, PH_SEC: seconds_next = add_second_digit(cur_seconds, digit);
        PH_FRAC: begin
          if (32'(cur_fcount) < FRACTION_DIGITS) begin
            fraction_next = frac_wide[FRAC_BITS-1:0];
            fcount_next   = cur_fcount + FCOUNT_BITS'(1);
          end
        end
        default: ;
      endcase
    end
    if (emit) begin
      minutes_next  = '0;
      seconds_next  = '0;
      fraction_next = '0;
      fcount_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_OPEN;
      minutes_acc    <= '0;
      seconds_acc    <= '0;
      fraction_acc   <= '0;
      fraction_count <= '0;
    end else if (take) begin
      phase          <= phase_next;
      minutes_acc    <= minutes_next;
      seconds_acc    <= seconds_next;
      fraction_acc   <= fraction_next;
      fraction_count <= fcount_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_ready) begin
      snap_valid <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready) begin
      snap.status         <= finish ? STATUS_TIME : STATUS_END;
      snap.minutes        <= finish ? cur_minutes : '0;
      snap.seconds        <= finish ? cur_seconds : '0;
      snap.fraction       <= finish ? cur_fraction : '0;
      snap.fraction_count <= finish ? cur_fcount : '0;
    end
  end

endmodule

@@ rtl/lrcts_time.sv @@
// Millisecond arithmetic of the lyric timestamp parser: constant products
// in one stage, sum and saturation in the output stage. Depends on lrcts_pkg.
module lrcts_time import lrcts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 snap_valid,
  input  snap_t                snap,
  output logic                 snap_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [TIME_BITS-1:0] time_ms,
  output logic                 status
);

  logic                     prod_valid;
  logic                     prod_status;
  logic [MIN_PROD_BITS-1:0] min_prod;
  logic [SEC_PROD_BITS-1:0] sec_prod;
  logic [FRAC_BITS-1:0]     frac_ms;
  logic [FRAC_BITS-1:0]     frac_scaled;
  logic                     out_ready;
  logic [SUM_BITS-1:0]      sum;
  logic [SUM_BITS-1:0]      time_max_wide;

  assign out_ready  = !out_valid || !out_stall;
  assign snap_ready = !prod_valid || out_ready;

  // Kept fraction digits are scaled up to three digits of milliseconds.
  always_comb begin
    unique case (snap.fraction_count)
      FCOUNT_BITS'(1): frac_scaled = FRAC_BITS'(snap.fraction * FRAC_BITS'(100));
      FCOUNT_BITS'(2): frac_scaled = FRAC_BITS'(snap.fraction * FRAC_BITS'(10));
      default:         frac_scaled = snap.fraction;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (snap_ready) begin
      prod_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready) begin
      prod_status <= snap.status;
      min_prod    <= MIN_PROD_BITS'(snap.minutes) * MIN_PROD_BITS'(MS_PER_MINUTE);
      sec_prod    <= SEC_PROD_BITS'(snap.seconds) * SEC_PROD_BITS'(MS_PER_SECOND);
      frac_ms     <= frac_scaled;
    end
  end

  assign sum = SUM_BITS'(min_prod) + SUM_BITS'(sec_prod) + SUM_BITS'(frac_ms);
  assign time_max_wide = {{(SUM_BITS-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      status  <= prod_status;
      time_ms <= (sum > time_max_wide) ? '1 : sum[TIME_BITS-1:0];
    end
  end

endmodule

@@ rtl/lrc_timestamp_parser_top.sv @@
// Top level of the lyric timestamp parser: byte handshake, parse state
// machine and millisecond arithmetic. Depends on lrcts_pkg, lrcts_parse, lrcts_time.
//
// A result appears on the output once the byte that completes or breaks a
// timestamp is accepted and has passed the snapshot, product and output registers.
// Throughput: one byte per cycle while in_stall is low; the parse state updates
// in the cycle of acceptance, so consecutive bytes flow without gaps.
// Reset: synchronous rst returns the parser to expecting an opening bracket
// with all accumulators cleared and empties the result pipeline.
module lrc_timestamp_parser_top import lrcts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           byte_value,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [TIME_BITS-1:0] time_ms,
  output logic                 status
);

  logic  take;
  logic  snap_valid;
  logic  snap_ready;
  snap_t snap;

  // The input and the snapshot register move together whenever the product
  // stage can take an item, so bytes keep flowing while one result waits at
  // the output. The input is held only while the product stage is full and
  // the output is stalled.
  assign in_stall = !snap_ready;
  assign take     = in_valid && !in_stall;

  // The parser consumes every accepted byte and produces a snapshot item only
  // when a timestamp closes or the list ends.
  lrcts_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .byte_value (byte_value),
    .restart    (restart),
    .snap_ready (snap_ready),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  // The snapshot is converted to milliseconds over two registered stages.
  lrcts_time u_time (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .time_ms    (time_ms),
    .status     (status)
  );

endmodule

@@ tb/lrc_timestamp_parser_top_tb.sv @@
// Self-checking testbench for lrc_timestamp_parser_top: sends lyric line bytes,
// predicts each timestamp or end-of-list result and checks it against the output.
// Depends on lrcts_pkg and the parser RTL.
module lrc_timestamp_parser_top_tb;
  import lrcts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Minimum number of bytes sent by the random part, ignored ones included.
  localparam int RANDOM_ITEMS = 1400;
  // Bytes at the end of the run that are sent with no idling on either side.
  localparam int QUIET_TAIL = 200;
  // The pipeline holds the snapshot, product and output registers; the final wait leaves some margin on top.
  localparam int DRAIN_CYCLES = 12;
  // Run limit, many times the slowest legal run.
  localparam int CYCLE_LIMIT = 200000;

  // One expected result: the time in milliseconds and the status bit.
  typedef struct packed {
    logic                 st;
    logic [TIME_BITS-1:0] ms;
  } stamp_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           byte_value = 8'h00;
  logic                 restart = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [TIME_BITS-1:0] time_ms;
  logic                 status;

  lrc_timestamp_parser_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_value (byte_value),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .time_ms    (time_ms),
    .status     (status)
  );

  // Parser state as the testbench tracks it, updated at each accepted item.
  phase_t                 parse_ph = PH_OPEN;
  logic [MINUTE_BITS-1:0] minute_acc = '0;
  logic [SECOND_BITS-1:0] second_acc = '0;
  logic [FRAC_BITS-1:0]   frac_acc = '0;
  logic [FCOUNT_BITS-1:0] frac_kept = '0;

  // Results the parser still owes, oldest first.
  stamp_t stamp_q[$];
  stamp_t want;

  // Bytes of the line currently being sent.
  logic [7:0] line_q[$];

  int  errors = 0;
  int  cycles = 0;
  int  sent_items = 0;
  bit  idle_en = 1'b0;
  int  rx_hold = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run is cut off if it ever takes far longer than the slowest correct
  // run could; this also catches a parser that stops accepting bytes.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime, stamp_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side: random stall bursts while idling is enabled. A burst starts
  // by raising out_stall and then holds it for the remaining count.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      rx_hold <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Appends one byte to the end of the line being built.
  function automatic void append_byte(logic [7:0] b);
    line_q.insert(line_q.size(), b);
  endfunction

  // Appends one result to the end of the list of owed results.
  function automatic void owe_result(stamp_t r);
    stamp_q.insert(stamp_q.size(), r);
  endfunction

  // Saturating decimal shift: acc * 10 + d, clamped to an all-ones value of
  // the given width.
  function automatic longint unsigned shift_in_digit(longint unsigned acc, logic [3:0] d,
                                                     int bits);
    longint unsigned top;
    longint unsigned v;
    top = (64'd1 << bits) - 64'd1;
    v = acc * 64'd10 + 64'(d);
    return (v > top) ? top : v;
  endfunction

  // Advances the tracked parser by one accepted item and queues the result
  // that this byte causes, if any.
  function automatic void track_byte(logic [7:0] c, logic rs);
    logic            is_digit;
    logic [3:0]      d;
    logic            done;
    logic            broken;
    longint unsigned frac;
    longint unsigned total;
    int              k;
    stamp_t          res;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d = 4'(c - CH_ZERO);
    done = 1'b0;
    broken = 1'b0;
    if (rs) begin
      parse_ph = PH_OPEN;
      minute_acc = '0;
      second_acc = '0;
      frac_acc = '0;
      frac_kept = '0;
    end
    case (parse_ph)
      PH_OPEN: begin
        if (c == CH_OPEN) parse_ph = PH_MIN_FIRST;
        else broken = 1'b1;
      end
      PH_MIN_FIRST, PH_MIN: begin
        if (is_digit) begin
          minute_acc = MINUTE_BITS'(shift_in_digit(minute_acc, d, MINUTE_BITS));
          parse_ph = PH_MIN;
        end else if (parse_ph == PH_MIN && c == CH_COLON) begin
          parse_ph = PH_SEC_FIRST;
        end else begin
          broken = 1'b1;
        end
      end
      PH_SEC_FIRST, PH_SEC: begin
        if (is_digit) begin
          second_acc = SECOND_BITS'(shift_in_digit(second_acc, d, SECOND_BITS));
          parse_ph = PH_SEC;
        end else if (parse_ph == PH_SEC && (c == CH_DOT || c == CH_COMMA)) begin
          parse_ph = PH_FRAC;
        end else if (parse_ph == PH_SEC && c == CH_CLOSE) begin
          done = 1'b1;
        end else begin
          broken = 1'b1;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          // Digits past the kept count are consumed without effect.
          if (frac_kept < FRACTION_DIGITS) begin
            frac_acc = FRAC_BITS'(frac_acc * 10 + d);
            frac_kept = frac_kept + 1'b1;
          end
        end else if (c == CH_CLOSE) begin
          done = 1'b1;
        end else begin
          broken = 1'b1;
        end
      end
      default: parse_ph = PH_DEAD;
    endcase
    if (done) begin
      // Scale the kept digits up to milliseconds; no digits means zero.
      frac = frac_acc;
      if (frac_kept != 0) begin
        for (k = int'(frac_kept); k < 3; k++) frac = frac * 10;
      end
      total = 64'(minute_acc) * 64'(MS_PER_MINUTE) + 64'(second_acc) * 64'(MS_PER_SECOND)
              + frac;
      if (total > ((64'd1 << TIME_BITS) - 64'd1)) total = (64'd1 << TIME_BITS) - 64'd1;
      res.st = STATUS_TIME;
      res.ms = TIME_BITS'(total);
      owe_result(res);
      parse_ph = PH_OPEN;
    end
    if (broken) begin
      res.st = STATUS_END;
      res.ms = '0;
      owe_result(res);
      parse_ph = PH_DEAD;
    end
    if (done || broken) begin
      minute_acc = '0;
      second_acc = '0;
      frac_acc = '0;
      frac_kept = '0;
    end
  endfunction

  // Watches both handshakes. Values are read as they stood before this edge,
  // so an accepted input item is folded into the prediction first and any
  // accepted result is then matched with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) track_byte(byte_value, restart);
      if (out_valid && !out_stall) begin
        if (stamp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual status %0d time_ms %0d",
                   $realtime, status, time_ms);
        end else begin
          want = stamp_q.pop_front();
          if (status !== want.st) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $realtime, want.st, status);
          end
          if (time_ms !== want.ms) begin
            errors++;
            $display("%0t: time_ms mismatch, expected %0d, actual %0d",
                     $realtime, want.ms, time_ms);
          end
        end
      end
    end
  end

  // Sends one item and returns at the edge where it is accepted. While idling
  // is enabled a short gap may come first.
  task automatic send_item(input logic [7:0] b, input logic rs);
    sent_items++;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_value <= b;
    restart <= rs;
    do @(posedge clk); while (in_stall);
  endtask

  // Sends the bytes in line_q; only the first one may carry restart.
  task automatic send_line(input logic rs);
    foreach (line_q[i]) send_item(line_q[i], (i == 0) ? rs : 1'b0);
  endtask

  function automatic void load_text(string s);
    line_q.delete();
    foreach (s[i]) append_byte(s[i]);
  endfunction

  // Lowers valid and holds off until every expected result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (stamp_q.size() != 0);
  endtask

  function automatic void add_digits(int n);
    repeat (n) append_byte(8'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  // Digit run lengths: mostly short, sometimes empty (a malformed field) and
  // now and then long enough to saturate.
  function automatic int pick_run();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 0;
    if (r < 12) return $urandom_range(1, 2);
    if (r < 15) return $urandom_range(3, 4);
    return $urandom_range(5, 7);
  endfunction

  // A byte biased toward the characters that the parser cares about.
  function automatic logic [7:0] pick_noise();
    case ($urandom_range(0, 7))
      0: return CH_OPEN;
      1: return CH_CLOSE;
      2: return CH_COLON;
      3: return ($urandom_range(0, 1) != 0) ? CH_DOT : CH_COMMA;
      4: return 8'(CH_ZERO + $urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Appends one well-formed timestamp with random content, apart from the
  // occasional empty minute or second run.
  function automatic void add_stamp();
    append_byte(CH_OPEN);
    add_digits(pick_run());
    append_byte(CH_COLON);
    add_digits(pick_run());
    case ($urandom_range(0, 2))
      0: ;
      1: begin
        append_byte(CH_DOT);
        add_digits($urandom_range(0, 5));
      end
      default: begin
        append_byte(CH_COMMA);
        add_digits($urandom_range(0, 5));
      end
    endcase
    append_byte(CH_CLOSE);
  endfunction

  // Both separators, one and zero fraction digits, back-to-back timestamps,
  // the smallest legal timestamp, text after the list and bytes ignored after
  // the list has ended.
  task automatic test_separators();
    load_text("[1:2.5][3:4,]");
    send_line(1'b1);
    load_text("[0:0] x");
    send_line(1'b1);
  endtask

  // Minutes and seconds beyond their widths saturate; fraction digits past
  // the third are skipped. This drives minutes and seconds to their largest values.
  task automatic test_saturation();
    load_text("[99999:99999.12345]");
    send_line(1'b1);
  endtask

  // A partial timestamp dropped by restart, a colon with no minutes, a close
  // with no seconds, a byte ignored without restart, and the byte of all ones.
  task automatic test_malformed();
    load_text("[12");
    send_line(1'b1);
    load_text("[:");
    send_line(1'b1);
    load_text("]");
    send_line(1'b0);
    load_text("[1:]");
    send_line(1'b1);
    line_q = '{8'hFF};
    send_line(1'b1);
  endtask

  // Random lines: mostly runs of well-formed timestamps with random content
  // and a random tail, some with one corrupted byte, and some pure noise.
  // Idling is switched on and off per line and is off for the final stretch.
  task automatic test_random();
    int  pos;
    bit  paused;
    paused = 1'b0;
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      idle_en = (sent_items < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      if (!paused && sent_items >= RANDOM_ITEMS / 2) begin
        // Let the output catch up completely once before carrying on.
        wait_drained();
        paused = 1'b1;
      end
      line_q.delete();
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(1, 3)) add_stamp();
        case ($urandom_range(0, 3))
          0: ;  // the line just stops, no end-of-list result
          1: append_byte(8'($urandom_range(0, 255)));
          default: begin
            // Lyric text: the first byte ends the list, the rest is ignored.
            append_byte(8'h20);
            repeat ($urandom_range(0, 3)) append_byte(8'($urandom_range(0, 255)));
          end
        endcase
        if ($urandom_range(0, 4) == 0) begin
          pos = $urandom_range(0, line_q.size() - 1);
          line_q[pos] = pick_noise();
        end
      end else begin
        repeat ($urandom_range(1, 6)) append_byte(pick_noise());
      end
      // Most lines start with restart; the rest continue whatever state the
      // previous line left, which also exercises a dead parser.
      send_line($urandom_range(0, 7) != 0);
    end
    idle_en = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_en = 1'b1;
    test_separators();
    test_saturation();
    test_malformed();
    test_random();
    // Everything has been sent: wait for the last results, then wait out the
    // drain margin in case anything extra comes out.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
